// ===== sv/first_seen_id_assigner_unit_assert.svh =====
// assertion macros shared by the first-seen id assigner rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef FIRST_SEEN_ID_ASSIGNER_UNIT_ASSERT_SVH
`define FIRST_SEEN_ID_ASSIGNER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define FSIA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsia assertion failed");

`define FSIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsia assertion failed");

`else

`define FSIA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define FSIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/fsia_pkg.sv =====
// shared types for the first-seen id assigner
// transaction structs and the lookup engine state encoding; no dependencies
package fsia_pkg;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic        start_new_set;
    } t_key_item;

    typedef struct packed {
        logic [7:0] dense_id;
        logic       is_new;
        logic [8:0] distinct_count;
        logic       overflow;
    } t_result_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_eng_state;

endpackage

// ===== sv/fsia_fifo.sv =====
// small register queue with push/full and pop/empty sides
// generic width; depends on first_seen_id_assigner_unit_assert.svh
`include "first_seen_id_assigner_unit_assert.svh"

module fsia_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `FSIA_ASSERT_IMPLY(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `FSIA_ASSERT_NEXT(a_fifo_fill, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1)
    `FSIA_ASSERT_NEXT(a_fifo_drain, i_clk, i_rst_n, do_pop && !do_push, r_count == $past(r_count) - 1'b1)

endmodule

// ===== sv/fsia_engine.sv =====
// lookup engine: scans the stored keys one per cycle and inserts misses
// depends on fsia_pkg and first_seen_id_assigner_unit_assert.svh
`include "first_seen_id_assigner_unit_assert.svh"

module fsia_engine #(
    parameter int ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  fsia_pkg::t_key_item   i_item,
    output logic                  o_item_take,
    output logic                  o_res_valid,
    output fsia_pkg::t_result_item o_res,
    input  logic                  i_res_full
);

    import fsia_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [127:0]   r_mem [ENTRIES];
    logic [127:0]   r_rd_data;
    t_eng_state     r_state;
    t_eng_state     n_state;
    logic [127:0]   r_key;
    logic [127:0]   n_key;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  r_rd_idx;
    logic [CW-1:0]  n_rd_idx;
    logic           r_cmp_vld;
    logic           n_cmp_vld;
    logic [IW-1:0]  r_cmp_idx;
    logic [IW-1:0]  n_cmp_idx;
    t_result_item   r_res;
    t_result_item   n_res;
    logic           rd_issue;
    logic           hit;
    logic           wr_en;
    logic [CW+8:0]  cnt_ext;
    logic [IW+7:0]  id_ext;

    assign o_res = r_res;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_res       = r_res;
        o_item_take = 1'b0;
        o_res_valid = 1'b0;
        wr_en       = 1'b0;
        rd_issue    = 1'b0;
        hit         = 1'b0;
        cnt_ext     = '0;
        id_ext      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_take = 1'b1;
                    n_key       = {i_item.key_high, i_item.key_low};
                    if (i_item.start_new_set) begin
                        n_count = '0;
                    end
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_issue  = (r_rd_idx < r_count);
                hit       = r_cmp_vld && (r_rd_data == r_key);
                n_cmp_vld = rd_issue;
                n_cmp_idx = r_rd_idx[IW-1:0];
                if (rd_issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (hit) begin
                    id_ext               = (IW+8)'(r_cmp_idx);
                    cnt_ext              = (CW+9)'(r_count);
                    n_res.dense_id       = id_ext[7:0];
                    n_res.is_new         = 1'b0;
                    n_res.distinct_count = cnt_ext[8:0];
                    n_res.overflow       = 1'b0;
                    n_state              = S_EMIT;
                end else if (!rd_issue) begin
                    if (r_count < CW'(ENTRIES)) begin
                        wr_en                = 1'b1;
                        n_count              = r_count + 1'b1;
                        id_ext               = (IW+8)'(r_count[IW-1:0]);
                        cnt_ext              = (CW+9)'(n_count);
                        n_res.dense_id       = id_ext[7:0];
                        n_res.is_new         = 1'b1;
                        n_res.distinct_count = cnt_ext[8:0];
                        n_res.overflow       = 1'b0;
                    end else begin
                        cnt_ext              = (CW+9)'(r_count);
                        n_res.dense_id       = '0;
                        n_res.is_new         = 1'b0;
                        n_res.distinct_count = cnt_ext[8:0];
                        n_res.overflow       = 1'b1;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_res_valid = !i_res_full;
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
    end

    // key store: one read and one write port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
        if (wr_en) begin
            r_mem[r_count[IW-1:0]] <= r_key;
        end
    end

    `FSIA_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRIES))
    `FSIA_ASSERT_IMPLY(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN, r_rd_idx <= r_count)
    `FSIA_ASSERT_IMPLY(a_ovf_full, i_clk, i_rst_n, r_state == S_EMIT && r_res.overflow, r_count == CW'(ENTRIES) && !r_res.is_new)
    `FSIA_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, wr_en, r_count == $past(r_count) + 1'b1)
    `FSIA_ASSERT_NEXT(a_hit_emit, i_clk, i_rst_n, hit, r_state == S_EMIT && !r_res.is_new)

endmodule

// ===== sv/first_seen_id_assigner_unit.sv =====
// top level of the first-seen id assigner (dictionary encoder for 128-bit keys)
// depends on fsia_pkg, fsia_fifo and fsia_engine
// Each key transaction gets a dense id in order of first appearance; a key
// seen before returns its stored id, a new key takes the next free id, and
// start_new_set empties the table before its key is handled. Keys queue in
// a two-entry input queue, a lookup engine compares them against the stored
// keys one entry per cycle through the single read port of the key memory,
// and results leave through a two-entry output queue. A key is compared
// against the stored keys up to and including a match, or against all
// stored keys on a miss, and its result waits in the engine while the
// output queue is full. The next key can be taken the cycle after the
// result leaves the engine.
// No clearing pass is needed after reset.
module first_seen_id_assigner_unit #(
    parameter int ENTRIES = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  fsia_pkg::t_key_item    i_in_item,
    output logic                   empty,
    input  logic                   pop,
    output fsia_pkg::t_result_item o_out_item
);

    import fsia_pkg::*;

    localparam int KEY_W = $bits(t_key_item);
    localparam int RES_W = $bits(t_result_item);

    logic [KEY_W-1:0] in_q_data;
    logic             in_q_empty;
    logic             eng_take;
    logic             eng_res_valid;
    t_result_item     eng_res;
    logic             out_q_full;
    logic [RES_W-1:0] out_q_data;

    fsia_fifo #(
        .WIDTH (KEY_W),
        .DEPTH (2)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (i_in_item),
        .i_pop   (eng_take),
        .o_empty (in_q_empty),
        .o_data  (in_q_data)
    );

    fsia_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!in_q_empty),
        .i_item       (t_key_item'(in_q_data)),
        .o_item_take  (eng_take),
        .o_res_valid  (eng_res_valid),
        .o_res        (eng_res),
        .i_res_full   (out_q_full)
    );

    fsia_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (eng_res_valid),
        .o_full  (out_q_full),
        .i_data  (eng_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_q_data)
    );

    assign o_out_item = t_result_item'(out_q_data);

endmodule

// ===== verif/first_seen_id_assigner_unit_tb.sv =====
// self-checking testbench for first_seen_id_assigner_unit (dense ids for 128-bit keys)
// depends on fsia_pkg and the rtl; a key-table predictor scores every result transaction
`timescale 1ns / 1ps

module first_seen_id_assigner_unit_tb;
    import fsia_pkg::*;

    localparam int TABLE_SIZE     = 256;
    localparam int RESET_CYCLES   = 10;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 1500;
    localparam int TAIL_CYCLES    = 2 * TABLE_SIZE;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 1650;
    localparam int MAX_REPORTS    = 20;

    typedef struct {
        t_key_item item;
        bit        drain_first;
    } t_pending_key;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         push = 1'b0;
    logic         full;
    t_key_item    i_in_item = '0;
    logic         empty;
    logic         pop = 1'b0;
    t_result_item o_out_item;

    t_pending_key key_stream[$];
    bit [127:0]   set_keys[$];
    bit [127:0]   old_keys[$];
    t_result_item expected_ids[$];

    bit [63:0]    tbl_high[TABLE_SIZE];
    bit [63:0]    tbl_low[TABLE_SIZE];
    bit           tbl_valid[TABLE_SIZE];
    int unsigned  tbl_count = 0;

    int results_due = 0;
    int errors = 0;
    int items_queued = 0;
    int results_seen = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_gap = 0;
    int recv_calm = 0;
    int recv_hold = 0;
    int idle_cycles = 0;

    first_seen_id_assigner_unit #(
        .ENTRIES(TABLE_SIZE)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .empty     (empty),
        .pop       (pop),
        .o_out_item(o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result_item encode_key(t_key_item k);
        t_result_item r;
        bit           hit;
        int unsigned  slot;
        r = '0;
        hit = 1'b0;
        slot = 0;
        if (k.start_new_set) begin
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            tbl_count = 0;
        end
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!hit && tbl_valid[i] && tbl_high[i] == k.key_high && tbl_low[i] == k.key_low) begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (!hit) begin
            if (tbl_count < TABLE_SIZE) begin
                slot = tbl_count;
                tbl_high[slot] = k.key_high;
                tbl_low[slot] = k.key_low;
                tbl_valid[slot] = 1'b1;
                tbl_count++;
                r.is_new = 1'b1;
            end else begin
                slot = 0;
                r.overflow = 1'b1;
            end
        end
        r.dense_id = slot[7:0];
        r.distinct_count = tbl_count[8:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic bit [127:0] random_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic bit [127:0] known_key();
        return set_keys[$urandom_range(0, set_keys.size() - 1)];
    endfunction

    function automatic bit [127:0] fresh_key();
        bit [127:0] k;
        k = random_key();
        case ($urandom_range(0, 9))
            0: begin
                // near miss of a key in the current set
                if (set_keys.size() > 0) begin
                    k = known_key();
                    k[$urandom_range(0, 127)] ^= 1'b1;
                end
            end
            1: begin
                if (old_keys.size() > 0) k = old_keys[$urandom_range(0, old_keys.size() - 1)];
            end
            2: begin
                k = '0;
                k[$urandom_range(0, 127)] = 1'b1;
                if ($urandom_range(0, 1)) k = ~k;
            end
            default: ;
        endcase
        return k;
    endfunction

    task automatic queue_key(bit [127:0] key, bit start, bit drain);
        t_pending_key p;
        bit           seen;
        seen = 1'b0;
        if (start) begin
            foreach (set_keys[j]) old_keys.push_back(set_keys[j]);
            while (old_keys.size() > 64) old_keys.delete(0);
            set_keys.delete();
        end
        foreach (set_keys[j]) if (set_keys[j] == key) seen = 1'b1;
        if (!seen) set_keys.push_back(key);
        p.item.key_high = key[127:64];
        p.item.key_low = key[63:0];
        p.item.start_new_set = start;
        p.drain_first = drain;
        key_stream.push_back(p);
        items_queued++;
    endtask

    task automatic run_set(int n, bit drain, bit open_with_start, int repeat_pct);
        bit [127:0] k;
        bit         start;
        for (int i = 0; i < n; i++) begin
            if (set_keys.size() > 0 && $urandom_range(0, 99) < repeat_pct) k = known_key();
            else k = fresh_key();
            start = (i == 0 && open_with_start) || ($urandom_range(0, 49) == 0);
            queue_key(k, start, drain && i == 0);
        end
    endtask

    // fill the table to the last entry, then mix hits and overflowing keys
    task automatic run_full_set(int extra, bit drain);
        bit [127:0] k;
        queue_key(fresh_key(), 1'b1, drain);
        while (set_keys.size() < TABLE_SIZE) begin
            if ($urandom_range(0, 4) == 0) k = known_key();
            else k = fresh_key();
            queue_key(k, 1'b0, 1'b0);
        end
        repeat (extra) begin
            if ($urandom_range(0, 1)) k = known_key();
            else k = random_key();
            queue_key(k, 1'b0, 1'b0);
        end
    endtask

    function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit took;
        bit offer;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            took = 1'b0;
            offer = push;
            if (push && !full) begin
                took = 1'b1;
                offer = 1'b0;
                key_stream.delete(0);
                if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    send_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
                end
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (key_stream.size() > 0 &&
                             (!key_stream[0].drain_first || (!took && results_due == 0))) begin
                    offer = 1'b1;
                    i_in_item <= key_stream[0].item;
                end
            end
            push <= offer;
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_result_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (push && !full) expected_ids.push_back(encode_key(i_in_item));
            if (pop && !empty) begin
                if (expected_ids.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got %p",
                                 $time, o_out_item);
                end else begin
                    want = expected_ids.pop_front();
                    check_field("dense_id", want.dense_id, o_out_item.dense_id);
                    check_field("is_new", want.is_new, o_out_item.is_new);
                    check_field("distinct_count", want.distinct_count, o_out_item.distinct_count);
                    check_field("overflow", want.overflow, o_out_item.overflow);
                end
                results_seen++;
                if (results_seen == HOLD_AT) begin
                    recv_hold = HOLD_CYCLES;
                end else if (recv_calm > 0) begin
                    recv_calm--;
                    recv_gap = 0;
                end else begin
                    recv_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 80);
                end
            end
            results_due <= expected_ids.size();
            if (recv_hold > 0) begin
                recv_hold--;
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit [127:0] ones;
        bit [127:0] alt;
        int         set_no;
        ones = '1;
        alt = {64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555};
        set_no = 0;

        // directed: extremes, repeats, half-key differences, start flag
        queue_key('0, 1'b0, 1'b0);
        queue_key('0, 1'b0, 1'b0);
        queue_key(ones, 1'b0, 1'b0);
        queue_key({64'h0, 64'hffff_ffff_ffff_ffff}, 1'b0, 1'b0);
        queue_key({64'hffff_ffff_ffff_ffff, 64'h0}, 1'b0, 1'b0);
        queue_key('0, 1'b0, 1'b0);
        queue_key(ones, 1'b0, 1'b0);
        queue_key(ones, 1'b1, 1'b0);
        queue_key('0, 1'b0, 1'b0);
        queue_key('0, 1'b1, 1'b0);
        queue_key({64'h8000_0000_0000_0000, 64'h1}, 1'b0, 1'b0);
        queue_key({64'h1, 64'h8000_0000_0000_0000}, 1'b0, 1'b0);
        queue_key(alt, 1'b1, 1'b0);
        queue_key(~alt, 1'b0, 1'b0);
        queue_key(alt, 1'b0, 1'b0);

        run_full_set(40, 1'b1);
        while (items_queued < ITEM_TARGET - 400) begin
            run_set($urandom_range(1, 40), set_no % 15 == 7, $urandom_range(0, 9) != 0,
                    $urandom_range(10, 70));
            set_no++;
        end
        run_full_set(40, 1'b1);
        while (items_queued < ITEM_TARGET) begin
            run_set($urandom_range(1, 40), 1'b0, $urandom_range(0, 9) != 0,
                    $urandom_range(10, 70));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (key_stream.size() != 0 || push || results_due != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
